// ===== sv/lrr_pkg.sv =====
// Shared types and constants for the ranged Lehmer random number generator.
`default_nettype none

package lrr_pkg;

	// Field widths.
	localparam int unsigned STATE_W = 31;
	localparam int unsigned BOUND_W = 31;
	localparam int unsigned SPREAD_W = BOUND_W + 1;
	localparam int unsigned MULT_W = 15;
	localparam int unsigned PROD_W = STATE_W + MULT_W;

	// Generator constants.
	localparam logic [MULT_W-1:0] MULTIPLIER = 15'd16807;
	localparam logic [STATE_W-1:0] MODULUS = 31'h7FFF_FFFF;
	localparam logic [STATE_W-1:0] SEED_RESET = 31'd1;

	// The remainder takes one restoring step per bit of the state.
	localparam int unsigned DIV_STEPS = STATE_W;
	localparam int unsigned CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic mul;
		logic fold;
		logic div_step;
		logic load_out;
	} lrr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic range_bad;
	} lrr_status_t;

endpackage

`default_nettype wire

// ===== sv/lrr_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
`default_nettype none

module lrr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  lrr_pkg::lrr_status_t  status,
	output lrr_pkg::lrr_cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_FOLD,
		S_DIV,
		S_DONE
	} state_t;

	state_t                    state_q;
	logic [lrr_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      accept;
	logic                      out_free;

	// An item enters only while the controller waits in idle.
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	// Command decode from the current state.
	always_comb begin
		cmd = '0;
		cmd.load_in = accept;
		cmd.mul = (state_q == S_MUL);
		cmd.fold = (state_q == S_FOLD);
		cmd.div_step = (state_q == S_DIV);
		cmd.load_out = (state_q == S_DONE) && out_free;
	end

	// State, bit counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= status.range_bad ? S_DONE : S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lrr_pkg::CNT_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/lrr_dp.sv =====
// Datapath: generator state, modular multiply, serial remainder and result register.
`default_nettype none

module lrr_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [lrr_pkg::STATE_W-1:0]   cfg_wr_data,
	input  wire logic [lrr_pkg::BOUND_W-1:0]   lower_bound,
	input  wire logic [lrr_pkg::BOUND_W-1:0]   upper_bound,
	input  lrr_pkg::lrr_cmd_t                  cmd,
	output lrr_pkg::lrr_status_t               status,
	output logic [lrr_pkg::BOUND_W-1:0]        value,
	output logic                               range_error
);

	logic [lrr_pkg::STATE_W-1:0]  gen_q;
	logic [lrr_pkg::BOUND_W-1:0]  lo_q;
	logic [lrr_pkg::SPREAD_W-1:0] spread_q;
	logic                         err_q;
	logic [lrr_pkg::PROD_W-1:0]   prod_q;
	logic [lrr_pkg::STATE_W-1:0]  quo_q;
	logic [lrr_pkg::STATE_W-1:0]  rem_q;
	logic [lrr_pkg::BOUND_W-1:0]  value_q;
	logic                         range_error_q;

	logic [lrr_pkg::SPREAD_W-1:0] fold_sum;
	logic [lrr_pkg::STATE_W-1:0]  fold_res;
	logic [lrr_pkg::SPREAD_W-1:0] trial;
	logic [lrr_pkg::STATE_W-1:0]  rem_next;
	logic [lrr_pkg::BOUND_W-1:0]  sum_out;

	// A range whose lower bound is not below its upper bound is rejected on entry.
	assign status.range_bad = (lower_bound >= upper_bound);

	// Fold the product: 2^31 is one modulo 2^31-1, so high and low halves add.
	always_comb begin
		fold_sum = {1'b0, prod_q[lrr_pkg::STATE_W-1:0]}
			+ lrr_pkg::SPREAD_W'(prod_q[lrr_pkg::PROD_W-1:lrr_pkg::STATE_W]);
		if (fold_sum >= {1'b0, lrr_pkg::MODULUS}) begin
			fold_res = lrr_pkg::STATE_W'(fold_sum - {1'b0, lrr_pkg::MODULUS});
		end else begin
			fold_res = fold_sum[lrr_pkg::STATE_W-1:0];
		end
	end

	// One restoring remainder step; the remainder always stays below the spread.
	always_comb begin
		trial = {rem_q, quo_q[lrr_pkg::STATE_W-1]};
		if (trial >= spread_q) begin
			rem_next = lrr_pkg::STATE_W'(trial - spread_q);
		end else begin
			rem_next = trial[lrr_pkg::STATE_W-1:0];
		end
	end

	// The lower bound plus the remainder never exceeds the upper bound.
	assign sum_out = lo_q + rem_q;

	// Generator state: reloaded by a seed write, advanced at the fold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= lrr_pkg::SEED_RESET;
		end else if (cfg_wr_en) begin
			gen_q <= cfg_wr_data;
		end else if (cmd.fold) begin
			gen_q <= fold_res;
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			lo_q <= lower_bound;
			spread_q <= {1'b0, upper_bound} - {1'b0, lower_bound} + 1'b1;
			err_q <= status.range_bad;
		end
		if (cmd.mul) begin
			prod_q <= gen_q * lrr_pkg::MULTIPLIER;
		end
		if (cmd.fold) begin
			quo_q <= fold_res;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[lrr_pkg::STATE_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
		if (cmd.load_out) begin
			value_q <= err_q ? '0 : sum_out;
			range_error_q <= err_q;
		end
	end

	assign value = value_q;
	assign range_error = range_error_q;

endmodule

`default_nettype wire

// ===== sv/lehmer_ranged_random.sv =====
// Top level of the ranged Lehmer random number generator.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     lower_bound, upper_bound
//   out      output     out_valid / out_stall   value, range_error
//   cfg      input      cfg_wr_en               cfg_wr_data (seed)
//
// A valid range passes from acceptance through a multiply, a fold and the
// bit-serial remainder unit, then loads the result register and returns
// to idle before the next item is accepted. A range with lower bound not
// below upper bound skips the arithmetic and leaves the state untouched.
// Reset loads the state with 1; a seed write loads the state at once.
// A result held by out_stall keeps the next item waiting only at the end.
`default_nettype none

module lehmer_ranged_random (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [lrr_pkg::STATE_W-1:0] cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [lrr_pkg::BOUND_W-1:0] lower_bound,
	input  wire logic [lrr_pkg::BOUND_W-1:0] upper_bound,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [lrr_pkg::BOUND_W-1:0]      value,
	output logic                             range_error
);

	lrr_pkg::lrr_cmd_t    cmd;
	lrr_pkg::lrr_status_t status;

	// Sequencing.
	lrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic and storage.
	lrr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.cmd         (cmd),
		.status      (status),
		.value       (value),
		.range_error (range_error)
	);

endmodule

`default_nettype wire

// ===== sv/lrr_chk.sv =====
// Port-level checker for the ranged Lehmer random number generator, with its bind.
`default_nettype none

module lrr_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [lrr_pkg::BOUND_W-1:0] value,
	input wire logic                        range_error
);

	// An accepted item occupies the block, so the next one must wait.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken in the cycle after an accepted item");

	// A rejected range always reports zero.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> value == '0)
		else $error("range error with nonzero value");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(value) && $stable(range_error))
		else $error("result payload changed while stalled");

endmodule

bind lehmer_ranged_random lrr_chk u_lrr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.value       (value),
	.range_error (range_error)
);

`default_nettype wire
